@@ rtl/core/cht_pkg.sv @@
// shared types and constants for the chained hash table
`timescale 1ns / 1ps
package cht_pkg;

  localparam logic [63:0] FNV_PRIME  = 64'd16777619;
  localparam logic [63:0] FNV_OFFSET = 64'd2166136261;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_ERASE  = 3'd2,
    OP_LOOKUP_OR_INSERT = 3'd3,
    OP_COUNT  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ERASED    = 3'd4,
    ST_FULL      = 3'd5,
    ST_COUNT     = 3'd6
  } status_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] value_in;
    logic [4:0]  bucket_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value_out;
    logic [7:0]  chain_length;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_READ,
    S_CHECK,
    S_ADD,
    S_ADD_LINK,
    S_ERASE,
    S_ERASE_TAIL,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic hash_step;
    logic get_head;
    logic rd_entry;
    logic advance;
    logic add_alloc;
    logic add_link;
    logic do_erase;
    logic erase_fix;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic hash_done;
    logic cur_nil;
    logic match;
    logic steps_done;
    logic can_alloc;
  } stat_t;

endpackage

@@ rtl/core/cht_ctrl.sv @@
// controller state machine of the chained hash table
`timescale 1ns / 1ps
module cht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  cht_pkg::stat_t st,
  output cht_pkg::cmd_t  cmd,
  output logic           busy
);

  cht_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cht_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != cht_pkg::S_IDLE);
    case (state_r)
      cht_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = cht_pkg::S_HASH;
        end
      end
      cht_pkg::S_HASH: begin
        if (st.hash_done) begin
          state_nxt = cht_pkg::S_HEAD;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      cht_pkg::S_HEAD: begin
        cmd.get_head = 1'b1;
        state_nxt = cht_pkg::S_READ;
      end
      cht_pkg::S_READ: begin
        if (st.cur_nil || st.steps_done) begin
          if ((st.op == cht_pkg::OP_INSERT) || (st.op == cht_pkg::OP_LOOKUP_OR_INSERT))
            state_nxt = cht_pkg::S_ADD;
          else
            state_nxt = cht_pkg::S_DONE;
        end else begin
          cmd.rd_entry = 1'b1;
          state_nxt = cht_pkg::S_CHECK;
        end
      end
      cht_pkg::S_CHECK: begin
        if (st.match && (st.op != cht_pkg::OP_COUNT)) begin
          if (st.op == cht_pkg::OP_ERASE) state_nxt = cht_pkg::S_ERASE;
          else state_nxt = cht_pkg::S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt = cht_pkg::S_READ;
        end
      end
      cht_pkg::S_ADD: begin
        if (st.can_alloc) begin
          cmd.add_alloc = 1'b1;
          state_nxt = cht_pkg::S_ADD_LINK;
        end else begin
          state_nxt = cht_pkg::S_DONE;
        end
      end
      cht_pkg::S_ADD_LINK: begin
        cmd.add_link = 1'b1;
        state_nxt = cht_pkg::S_DONE;
      end
      cht_pkg::S_ERASE: begin
        cmd.do_erase = 1'b1;
        state_nxt = cht_pkg::S_ERASE_TAIL;
      end
      cht_pkg::S_ERASE_TAIL: begin
        cmd.erase_fix = 1'b1;
        state_nxt = cht_pkg::S_DONE;
      end
      cht_pkg::S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = cht_pkg::S_IDLE;
      end
      default: state_nxt = cht_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/cht_datapath.sv @@
// hash unit, pool memories and chain pointers of the chained hash table
`timescale 1ns / 1ps
module cht_datapath #(
  parameter int BUCKETS  = 32,
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cht_pkg::cmd_t      cmd,
  input  cht_pkg::in_item_t  in_item,
  output cht_pkg::stat_t     st,
  output logic               out_strobe,
  output cht_pkg::out_item_t out_item
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  logic [63:0] khi_mem [CAPACITY];
  logic [63:0] klo_mem [CAPACITY];
  logic [63:0] hash_mem [CAPACITY];
  logic [63:0] val_mem [CAPACITY];
  logic [PW-1:0] link_mem [CAPACITY];
  logic [PW-1:0] head_r [BUCKETS];
  logic [PW-1:0] tail_r [BUCKETS];

  cht_pkg::in_item_t item_r;
  logic [63:0] hash_r;
  logic [4:0]  octet_r;
  logic [PW-1:0] cur_r, prev_r, slot_sel, recycle_r, fill_r;
  logic [PW:0]   steps_r;
  logic [BW-1:0] bkt_r;
  logic [63:0] rd_khi_r, rd_klo_r, rd_hash_r, rd_val_r;
  logic [PW-1:0] rd_link_r, rcy_link_r;
  logic [2:0]  status_r;
  logic [7:0]  clen_r;
  logic        strobe_r;
  logic [PW-1:0] slot_hold_r;
  logic        add_done_r;

  logic [7:0]  octet;
  logic [127:0] key;
  logic [63:0] hash_x;
  logic [BW-1:0] hbkt;
  logic        qb_ok;

  assign key    = {item_r.key_hi, item_r.key_lo};
  assign octet  = key[8'd127 - {octet_r[3:0], 3'b000} -: 8];
  assign hash_x = hash_r ^ {56'd0, octet};
  assign hbkt   = BW'(hash_r % 64'(BUCKETS));
  assign qb_ok  = 32'(item_r.bucket_index) < BUCKETS;

  assign st.op         = item_r.op;
  assign st.hash_done  = octet_r[4];
  assign st.cur_nil    = (cur_r >= NIL);
  assign st.match      = (rd_hash_r == hash_r) && (rd_khi_r == item_r.key_hi)
                         && (rd_klo_r == item_r.key_lo);
  assign st.steps_done = (steps_r >= (PW+1)'(CAPACITY));
  assign st.can_alloc  = (recycle_r < NIL) || (fill_r < NIL);

  // pool memories, one write port each
  always_ff @(posedge clk) begin
    if (cmd.rd_entry) begin
      rd_khi_r  <= khi_mem[cur_r[IW-1:0]];
      rd_klo_r  <= klo_mem[cur_r[IW-1:0]];
      rd_hash_r <= hash_mem[cur_r[IW-1:0]];
      rd_val_r  <= val_mem[cur_r[IW-1:0]];
      rd_link_r <= link_mem[cur_r[IW-1:0]];
    end
    if (cmd.add_alloc) begin
      khi_mem[slot_sel[IW-1:0]]  <= item_r.key_hi;
      klo_mem[slot_sel[IW-1:0]]  <= item_r.key_lo;
      hash_mem[slot_sel[IW-1:0]] <= hash_r;
      val_mem[slot_sel[IW-1:0]]  <= (item_r.op == cht_pkg::OP_INSERT) ? item_r.value_in : 64'd0;
    end
    if (cmd.add_alloc) begin
      link_mem[slot_sel[IW-1:0]] <= NIL;
    end else if (cmd.add_link) begin
      if (tail_r[bkt_r] < NIL) link_mem[tail_r[bkt_r][IW-1:0]] <= slot_hold_r;
    end else if (cmd.do_erase) begin
      if (prev_r < NIL) link_mem[prev_r[IW-1:0]] <= rd_link_r;
    end else if (cmd.erase_fix) begin
      link_mem[cur_r[IW-1:0]] <= recycle_r;
    end
    rcy_link_r <= link_mem[recycle_r[IW-1:0]];
  end

  // slot to use for an add: recycle first, then fresh
  always_comb begin
    slot_sel = (recycle_r < NIL) ? recycle_r : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUCKETS; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
      end
      recycle_r <= NIL;
      fill_r    <= '0;
      strobe_r  <= 1'b0;
    end else begin
      strobe_r <= cmd.finish;
      if (cmd.add_alloc) begin
        if (recycle_r < NIL) recycle_r <= rcy_link_r;
        else fill_r <= fill_r + 1'b1;
      end
      if (cmd.add_link) begin
        if (!(tail_r[bkt_r] < NIL)) head_r[bkt_r] <= slot_hold_r;
        tail_r[bkt_r] <= slot_hold_r;
      end
      if (cmd.do_erase) begin
        if (!(prev_r < NIL)) head_r[bkt_r] <= rd_link_r;
        if (tail_r[bkt_r] == cur_r) tail_r[bkt_r] <= prev_r;
      end
      if (cmd.erase_fix) recycle_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r  <= in_item;
      hash_r  <= cht_pkg::FNV_OFFSET;
      octet_r <= '0;
      status_r <= cht_pkg::ST_NOT_FOUND;
      clen_r  <= '0;
    end
    if (cmd.hash_step) begin
      // times the fnv prime: 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
      hash_r  <= (hash_x << 24) + (hash_x << 8) + (hash_x << 7) + (hash_x << 4)
                 + (hash_x << 1) + hash_x;
      octet_r <= octet_r + 5'd1;
    end
    if (cmd.get_head) begin
      prev_r  <= NIL;
      steps_r <= '0;
      if (item_r.op == cht_pkg::OP_COUNT) begin
        status_r <= cht_pkg::ST_COUNT;
        bkt_r <= BW'(item_r.bucket_index);
        cur_r <= qb_ok ? head_r[BW'(item_r.bucket_index)] : NIL;
      end else begin
        bkt_r <= hbkt;
        cur_r <= head_r[hbkt];
      end
    end
    if (cmd.advance) begin
      prev_r  <= cur_r;
      cur_r   <= rd_link_r;
      steps_r <= steps_r + 1'b1;
      if (item_r.op == cht_pkg::OP_COUNT && clen_r != 8'hFF) clen_r <= clen_r + 8'd1;
    end
    if (cmd.add_alloc) slot_hold_r <= slot_sel;
  end

  // result selection on the final cycle
  logic [2:0]  res_status;
  logic [63:0] res_val;
  logic        found;
  assign found = !st.cur_nil && !st.steps_done && st.match && item_r.op != cht_pkg::OP_COUNT;

  always_comb begin
    res_status = status_r;
    res_val = '0;
    case (item_r.op)
      cht_pkg::OP_INSERT:
        res_status = found ? cht_pkg::ST_DUPLICATE :
                     (add_done_r ? cht_pkg::ST_INSERTED : cht_pkg::ST_FULL);
      cht_pkg::OP_LOOKUP: begin
        res_status = found ? cht_pkg::ST_FOUND : cht_pkg::ST_NOT_FOUND;
        res_val = found ? rd_val_r : 64'd0;
      end
      cht_pkg::OP_ERASE:
        res_status = found ? cht_pkg::ST_ERASED : cht_pkg::ST_NOT_FOUND;
      cht_pkg::OP_LOOKUP_OR_INSERT: begin
        res_status = found ? cht_pkg::ST_FOUND :
                     (add_done_r ? cht_pkg::ST_INSERTED : cht_pkg::ST_FULL);
        res_val = found ? rd_val_r : 64'd0;
      end
      cht_pkg::OP_COUNT: res_status = cht_pkg::ST_COUNT;
      default: res_status = cht_pkg::ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) add_done_r <= 1'b0;
    else if (cmd.add_alloc) add_done_r <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.status       <= res_status;
      out_item.value_out    <= res_val;
      out_item.chain_length <= (item_r.op == cht_pkg::OP_COUNT) ? clen_r : 8'd0;
    end
  end

  assign out_strobe = strobe_r;

endmodule

@@ rtl/core/chained_hash_table.sv @@
// top level of the chained hash table
// an operation hashes the key, reads the bucket head, reads and checks each chain entry walked, then finishes
// the result strobe follows the last busy cycle
// throughput: one operation at a time; the next start transfer is taken in the strobe cycle
// reset clears bucket heads, tails and the free pool pointers
// the result strobe lasts one cycle; the receiver cannot stall
`timescale 1ns / 1ps
module chained_hash_table #(
  parameter int BUCKETS  = 32,
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cht_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output cht_pkg::out_item_t out_item
);

  cht_pkg::cmd_t  cmd;
  cht_pkg::stat_t st;

  cht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .st(st), .cmd(cmd), .busy(busy)
  );

  cht_datapath #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_item), .st(st),
    .out_strobe(out_strobe), .out_item(out_item)
  );

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result without finishing operation");
  a_no_start_ack_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start transfer not taken");
  a_one_hot_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.add_alloc, cmd.add_link, cmd.do_erase, cmd.erase_fix}))
    else $error("conflicting pool commands");

endmodule
